// ===== hw/rtl/vrp_pkg.sv =====
package vrp_pkg;
  localparam int PATTERN_DEPTH = 8192;
  localparam int NAME_DEPTH = 2048;
  localparam int PAT_AW = $clog2(PATTERN_DEPTH);
  localparam int NAME_AW = $clog2(NAME_DEPTH);

  typedef enum logic [1:0] {
    MODE_READ = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_VBL_BEGIN = 2'd2,
    MODE_VBL_END = 2'd3
  } mode_t;

  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_MASK = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR = 3'd6;
  localparam logic [2:0] REG_DATA = 3'd7;

  localparam logic [1:0] MIR_VERT = 2'd0;
  localparam logic [1:0] MIR_HORZ = 2'd1;
  localparam logic [1:0] MIR_LOW = 2'd2;
  localparam logic [1:0] MIR_HIGH = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_raise;
  } out_item_t;

  function automatic logic [NAME_AW-1:0] name_index(input logic [13:0] a,
                                                    input logic [1:0] mir);
    logic [NAME_AW-1:0] r;
    r = '0;
    case (mir)
      MIR_VERT: r = a[NAME_AW-1:0];
      MIR_HORZ: r = {a[11], a[9:0]};
      MIR_LOW:  r = {1'b0, a[9:0]};
      MIR_HIGH: r = {1'b1, a[9:0]};
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] color_index(input logic [13:0] a);
    logic [4:0] c;
    c = a[4:0];
    if (c[4] && c[1:0] == 2'b00) c[4] = 1'b0;
    return c;
  endfunction
endpackage

// ===== hw/rtl/vrp_stream_if.sv =====
interface vrp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/video_register_port_unit.sv =====
// an accepted transaction is registered into item_r with busy_r set, then its result is registered into od_r
// no new transaction is accepted while busy_r is set (read of the stores, then write-back) or output is held
// the store read-modify-write through single-port memories is what holds the unit busy
// reset: synchronous active-low rst_n clears the control, status and address registers and the mirroring mode
// after reset a clearing pass steps through every pattern address and zeroes the stores, input is held off
module video_register_port_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  vrp_stream_if.sink           in_ch,
  vrp_stream_if.source         out_ch
);
  import vrp_pkg::*;

  logic [14:0] v_r, t_r;
  logic [2:0]  fx_r;
  logic        wp_r;
  logic [7:0]  ctrl_r, mask_r, stat_r, oam_a_r, buf_r, latch_r;
  logic [1:0]  mir_r;
  logic        busy_r;
  in_item_t    item_r;
  logic        ov_r;
  out_item_t   od_r;
  logic        clr_r;
  logic [PAT_AW-1:0] clr_cnt_r;

  logic [7:0] oam_mem [256];
  logic [7:0] name_mem [NAME_DEPTH];
  logic [7:0] col_mem [32];
  logic [7:0] pat_mem [PATTERN_DEPTH];
  logic [7:0] oam_q, name_q, col_q, pat_q;

  logic [13:0] a;
  logic [13:0] na;
  assign a = v_r[13:0];
  assign na = (a > 14'h3EFF) ? a - 14'h1000 : a;

  wire        take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !clr_r && !busy_r && (!ov_r || out_ch.ready);
  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;

  // read phase on accept, with the address as it stands then
  always_ff @(posedge clk) begin
    if (take) begin
      oam_q  <= oam_mem[oam_a_r];
      name_q <= name_mem[name_index(na, mir_r)];
      col_q  <= col_mem[color_index(a)];
      pat_q  <= pat_mem[a[PAT_AW-1:0]];
    end
  end

  wire vbl = stat_r[7];
  wire rend = mask_r[3] || mask_r[4];
  wire is_rd = item_r.mode == MODE_READ;
  wire is_wr = item_r.mode == MODE_WRITE;
  wire [7:0] d = item_r.write_data;
  wire [14:0] v_inc = v_r + (ctrl_r[2] ? 15'd32 : 15'd1);

  always_ff @(posedge clk) begin
    if (clr_r) begin
      pat_mem[clr_cnt_r] <= 8'd0;
      name_mem[clr_cnt_r[NAME_AW-1:0]] <= 8'd0;
      col_mem[clr_cnt_r[4:0]] <= 8'd0;
      oam_mem[clr_cnt_r[7:0]] <= 8'd0;
    end else begin
      if (busy_r && is_wr && item_r.reg_index == REG_DATA) begin
        if (a < 14'h2000) pat_mem[a[PAT_AW-1:0]] <= d;
        else if (a > 14'h3EFF) col_mem[color_index(a)] <= d;
        else name_mem[name_index(a, mir_r)] <= d;
      end
      if (busy_r && is_wr && item_r.reg_index == REG_OAM_DATA && (vbl || !rend))
        oam_mem[oam_a_r] <= d;
    end
  end

  logic [7:0] rd;
  logic       nmi;
  always_comb begin
    rd = 8'd0;
    nmi = 1'b0;
    if (is_rd) begin
      case (item_r.reg_index)
        REG_STATUS:   rd = stat_r;
        REG_OAM_DATA: rd = oam_q;
        REG_DATA:     rd = (a > 14'h3EFF) ? col_q : buf_r;
        default:      rd = latch_r;
      endcase
    end else if (is_wr && item_r.reg_index == REG_CTRL) begin
      nmi = vbl && !ctrl_r[7] && d[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + PAT_AW'(1);
      if (&clr_cnt_r) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0; t_r <= '0; fx_r <= '0; wp_r <= 1'b0;
      ctrl_r <= '0; mask_r <= '0; stat_r <= '0; oam_a_r <= '0;
      buf_r <= '0; latch_r <= '0; mir_r <= '0;
      busy_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) mir_r <= cfg_wdata;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      if (take) begin
        item_r <= in_ch.data;
        busy_r <= 1'b1;
      end
      if (busy_r) begin
        busy_r <= 1'b0;
        ov_r <= 1'b1;
        od_r <= '{read_data: rd, nmi_raise: nmi};
        case (item_r.mode)
          MODE_READ: begin
            case (item_r.reg_index)
              REG_STATUS: begin
                latch_r <= rd; wp_r <= 1'b0; stat_r[7] <= 1'b0;
              end
              REG_OAM_DATA: begin
                latch_r <= rd;
                if (!vbl && rend) oam_a_r <= oam_a_r + 8'd1;
              end
              REG_DATA: begin
                latch_r <= rd;
                buf_r <= (a < 14'h2000) ? pat_q : name_q;
                v_r <= v_inc;
              end
              default: ;
            endcase
          end
          MODE_WRITE: begin
            latch_r <= d;
            case (item_r.reg_index)
              REG_CTRL: begin
                ctrl_r <= d; t_r[11:10] <= d[1:0];
              end
              REG_MASK: mask_r <= d;
              REG_SPR_ADDR: oam_a_r <= d;
              REG_OAM_DATA: oam_a_r <= oam_a_r + 8'd1;
              REG_SCROLL: begin
                if (!wp_r) begin
                  t_r[4:0] <= d[7:3]; fx_r <= d[2:0]; wp_r <= 1'b1;
                end else begin
                  t_r[14:12] <= d[2:0]; t_r[9:5] <= d[7:3]; wp_r <= 1'b0;
                end
              end
              REG_ADDR: begin
                if (!wp_r) begin
                  t_r[14:8] <= {1'b0, d[5:0]}; wp_r <= 1'b1;
                end else begin
                  t_r[7:0] <= d; v_r <= {t_r[14:8], d}; wp_r <= 1'b0;
                end
              end
              REG_DATA: v_r <= v_inc;
              default: ;
            endcase
          end
          MODE_VBL_BEGIN: stat_r[7] <= 1'b1;
          default: stat_r[7:5] <= 3'b000;
        endcase
      end
    end
  end
endmodule
